// File: rtl/siph_pkg.sv
// Shared types and constants for the SipHash-2-4 tag unit.
// Holds the lane struct, initialization and finalization constants and the rotate helper.
// No dependencies.
package siph_pkg;

  localparam logic [63:0] IV_A      = 64'h736f6d6570736575;
  localparam logic [63:0] IV_B      = 64'h646f72616e646f6d;
  localparam logic [63:0] IV_C      = 64'h6c7967656e657261;
  localparam logic [63:0] IV_D      = 64'h7465646279746573;
  localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;
  localparam int unsigned LEN_SHIFT = 56;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

endpackage

// File: rtl/siphash_message_tag.sv
// SipHash-2-4 tag over a byte stream: sequencer, packer and key registers.
// A byte that does not close a block is absorbed in the idle state; one that
// closes a block runs 4 half-round steps on the shared round unit, input stalled.
// A last word runs 4 (+4 if it closes a block) + 8 half-round steps, then the tag
// is registered at the output. Reset clears keys, counters and handshakes.
// Depends on siph_pkg and siph_half_round.
module siphash_message_tag (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] tag_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RND  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] PH_BLOCK = 2'd0;
  localparam logic [1:0] PH_FABS  = 2'd1;
  localparam logic [1:0] PH_FRND  = 2'd2;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  logic [1:0]       state_q, state_d;
  logic [1:0]       phase_q, phase_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             open_q, open_d;
  logic             pend_last_q, pend_last_d;
  logic [7:0]       count_q, count_d;
  logic [63:0]      partial_q, partial_d;
  logic [63:0]      block_q, block_d;
  logic [63:0]      key_low_q, key_high_q;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      tag_q, tag_d;
  siph_pkg::lanes_t lanes_q, lanes_d;
  siph_pkg::lanes_t cur_lanes, half_out;

  logic        in_accept;
  logic [63:0] base_partial, new_partial, final_blk;
  logic [7:0]  base_count, new_count;
  logic        blk_full;

  siph_half_round u_half (
    .lanes_i (lanes_q),
    .second_i(cnt_q[0]),
    .lanes_o (half_out)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign tag_o       = tag_q;

  always_comb begin
    if (open_q) begin
      cur_lanes    = lanes_q;
      base_partial = partial_q;
      base_count   = count_q;
    end else begin
      cur_lanes.a  = siph_pkg::IV_A ^ key_low_q;
      cur_lanes.b  = siph_pkg::IV_B ^ key_high_q;
      cur_lanes.c  = siph_pkg::IV_C ^ key_low_q;
      cur_lanes.d  = siph_pkg::IV_D ^ key_high_q;
      base_partial = '0;
      base_count   = '0;
    end
    new_partial = base_partial;
    new_count   = base_count;
    if (byte_valid_i) begin
      for (int i = 0; i < 8; i++) begin
        if (base_count[2:0] == 3'(i)) begin
          new_partial[8*i +: 8] = data_byte_i;
        end
      end
      new_count = base_count + 8'd1;
    end
    blk_full  = byte_valid_i && (new_count[2:0] == 3'd0);
    final_blk = new_partial | ({56'd0, new_count} << siph_pkg::LEN_SHIFT);
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    open_d      = open_q;
    pend_last_d = pend_last_q;
    count_d     = count_q;
    partial_d   = partial_q;
    block_d     = block_q;
    lanes_d     = lanes_q;
    out_valid_d = out_valid_q && out_stall_i;
    tag_d       = tag_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          open_d      = 1'b1;
          count_d     = new_count;
          lanes_d     = cur_lanes;
          pend_last_d = last_item_i;
          cnt_d       = '0;
          if (blk_full) begin
            lanes_d.d = cur_lanes.d ^ new_partial;
            block_d   = new_partial;
            partial_d = '0;
            phase_d   = PH_BLOCK;
            state_d   = ST_RND;
          end else if (last_item_i) begin
            lanes_d.d = cur_lanes.d ^ final_blk;
            block_d   = final_blk;
            partial_d = new_partial;
            phase_d   = PH_FABS;
            state_d   = ST_RND;
          end else begin
            partial_d = new_partial;
          end
        end
      end
      ST_RND: begin
        lanes_d = half_out;
        cnt_d   = cnt_q + 3'd1;
        unique case (phase_q)
          PH_BLOCK: begin
            if (cnt_q == 3'd3) begin
              lanes_d.a = half_out.a ^ block_q;
              cnt_d     = '0;
              if (pend_last_q) begin
                block_d   = {count_q, 56'd0};
                lanes_d.d = half_out.d ^ {count_q, 56'd0};
                phase_d   = PH_FABS;
              end else begin
                state_d = ST_IDLE;
              end
            end
          end
          PH_FABS: begin
            if (cnt_q == 3'd3) begin
              lanes_d.a = half_out.a ^ block_q;
              lanes_d.c = half_out.c ^ siph_pkg::FINAL_XOR;
              cnt_d     = '0;
              phase_d   = PH_FRND;
            end
          end
          PH_FRND: begin
            if (cnt_q == 3'd7) begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          tag_d       = lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;
          open_d      = 1'b0;
          count_d     = '0;
          partial_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_BLOCK;
      cnt_q       <= '0;
      open_q      <= 1'b0;
      pend_last_q <= 1'b0;
      count_q     <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
      key_low_q   <= '0;
      key_high_q  <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      open_q      <= open_d;
      pend_last_q <= pend_last_d;
      count_q     <= count_d;
      partial_q   <= partial_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
          REG_KEY_HIGH: key_high_q <= cfg_wdata_i;
          default:      key_low_q  <= key_low_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    block_q <= block_d;
    tag_q   <= tag_d;
  end

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("tag raised outside the done step");
  a_last_starts_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_item_i) |=> (state_q == ST_RND))
    else $error("last word did not start finalization");
  a_short_phase_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND && phase_q != PH_FRND) |-> !cnt_q[2])
    else $error("absorb step counter overran");
  a_done_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> open_q)
    else $error("finalization without an open message");
`endif

endmodule

// File: rtl/siph_half_round.sv
// Shared half of a SipHash round; the sequencer applies it twice per round.
// Depends on siph_pkg for the lane struct and rotate helper.
module siph_half_round (
  input  siph_pkg::lanes_t lanes_i,
  input  logic             second_i,
  output siph_pkg::lanes_t lanes_o
);

  logic [63:0] sum_ac;
  logic [63:0] sum_ca;

  always_comb begin
    lanes_o = lanes_i;
    if (!second_i) begin
      sum_ac    = lanes_i.a + lanes_i.b;
      sum_ca    = lanes_i.c + lanes_i.d;
      lanes_o.b = siph_pkg::rotl(lanes_i.b, 13) ^ sum_ac;
      lanes_o.a = siph_pkg::rotl(sum_ac, 32);
      lanes_o.d = siph_pkg::rotl(lanes_i.d, 16) ^ sum_ca;
      lanes_o.c = sum_ca;
    end else begin
      sum_ac    = lanes_i.a + lanes_i.d;
      sum_ca    = lanes_i.c + lanes_i.b;
      lanes_o.a = sum_ac;
      lanes_o.d = siph_pkg::rotl(lanes_i.d, 21) ^ sum_ac;
      lanes_o.b = siph_pkg::rotl(lanes_i.b, 17) ^ sum_ca;
      lanes_o.c = siph_pkg::rotl(sum_ca, 32);
    end
  end

endmodule
